>>> design/mpcsce_pkg.sv
// Shared types, widths and constants for the switching cost evaluator.
package mpcsce_pkg;

  // Fixed field widths.
  localparam int MASK_W  = 6;
  localparam int QW_W    = 16;
  localparam int SWC_W   = 24;
  localparam int PEN_W   = 4;
  localparam int LIM_W   = 15;
  localparam int COST_W  = 48;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Squared error magnitude clamp and saturation point of the positive terms.
  localparam int MAG_W   = 25;
  localparam int SQ_W    = 49;
  localparam logic [SQ_W-1:0] SQ_CAP = {1'b1, {(SQ_W-1){1'b0}}};

  // Sum of switch and overcurrent costs, integer units.
  localparam int SMALL_W = 8;

  // Number of pipeline registers from input to output.
  localparam int NSTG    = 7;

  // Alpha-beta-zero to abc matrix entries, Q1.15.
  localparam logic signed [15:0] M_AA = 16'sd26755;
  localparam logic signed [15:0] M_BA = -16'sd13376;
  localparam logic signed [15:0] M_BB = 16'sd23170;
  localparam logic signed [15:0] M_ZZ = 16'sd18920;

  // Register map.
  typedef enum logic [1:0] {
    REG_QUAD_WEIGHT   = 2'd0,
    REG_SWITCH_COSTS  = 2'd1,
    REG_OC_PENALTY    = 2'd2,
    REG_CURRENT_LIMIT = 2'd3
  } reg_idx_t;

  // Load enables of all pipeline registers, stage 1 first.
  typedef logic [NSTG-1:0] stg_en_t;

endpackage

>>> design/mpcsce_if.sv
// Request channel interfaces: candidate input and cost result.
interface mpcsce_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] ref_0;
  logic signed [SAMPLE_WIDTH-1:0] ref_1;
  logic signed [SAMPLE_WIDTH-1:0] ref_2;
  logic signed [SAMPLE_WIDTH-1:0] ref_3;
  logic signed [SAMPLE_WIDTH-1:0] ref_4;
  logic signed [SAMPLE_WIDTH-1:0] meas_0;
  logic signed [SAMPLE_WIDTH-1:0] meas_1;
  logic signed [SAMPLE_WIDTH-1:0] meas_2;
  logic signed [SAMPLE_WIDTH-1:0] meas_3;
  logic signed [SAMPLE_WIDTH-1:0] meas_4;
  logic [mpcsce_pkg::MASK_W-1:0]  prev_switches;
  logic [mpcsce_pkg::MASK_W-1:0]  cand_switches;

  modport source (
    output valid, ref_0, ref_1, ref_2, ref_3, ref_4,
    output meas_0, meas_1, meas_2, meas_3, meas_4, prev_switches, cand_switches,
    input  ready
  );
  modport sink (
    input  valid, ref_0, ref_1, ref_2, ref_3, ref_4,
    input  meas_0, meas_1, meas_2, meas_3, meas_4, prev_switches, cand_switches,
    output ready
  );
endinterface

interface mpcsce_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mpcsce_pkg::COST_W-1:0] cost;

  modport source (output valid, cost, input ready);
  modport sink (input valid, cost, output ready);
endinterface

>>> design/mpcsce_sq_lane.sv
// One squared-error lane: difference magnitude, then a registered square.
module mpcsce_sq_lane #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic [1:0]                     en,
  input  logic signed [SAMPLE_WIDTH-1:0] ref_i,
  input  logic signed [SAMPLE_WIDTH-1:0] meas_i,
  output logic [mpcsce_pkg::SQ_W-1:0]    sq_r
);
  import mpcsce_pkg::*;

  localparam int DW = SAMPLE_WIDTH + 1;
  localparam int XW = (DW > MAG_W + 1) ? DW : MAG_W + 1;

  logic signed [DW-1:0]  diff;
  logic [DW-1:0]         mag;
  logic [XW-1:0]         mag_x;
  logic                  over_nxt;
  logic                  over_r;
  logic [MAG_W-1:0]      mag_nxt;
  logic [MAG_W-1:0]      mag_r;
  logic [2*MAG_W-1:0]    prod;
  logic [SQ_W-1:0]       sq_nxt;

  // Absolute difference; anything above 2^24 squares past the cap.
  always_comb begin
    diff     = DW'(ref_i) - DW'(meas_i);
    mag      = diff[DW-1] ? DW'(-diff) : DW'(diff);
    mag_x    = XW'(mag);
    over_nxt = mag_x > (XW'(1) << 24);
    mag_nxt  = over_nxt ? '0 : mag_x[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_r  <= mag_nxt;
      over_r <= over_nxt;
    end
  end

  // Square of the clamped magnitude; 2^24 squared lands exactly on the cap.
  always_comb begin
    prod   = mag_r * mag_r;
    sq_nxt = over_r ? SQ_CAP : prod[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

>>> design/mpcsce_phase_lane.sv
// One abc phase lane: matrix row products, then an overcurrent compare.
module mpcsce_phase_lane #(
  parameter int                 SAMPLE_WIDTH = 16,
  parameter logic signed [15:0] C_ALPHA      = 16'sd0,
  parameter logic signed [15:0] C_BETA       = 16'sd0,
  parameter logic signed [15:0] C_ZERO       = 16'sd0
) (
  input  logic                           clk,
  input  logic [1:0]                     en,
  input  logic signed [SAMPLE_WIDTH-1:0] i_alpha,
  input  logic signed [SAMPLE_WIDTH-1:0] i_beta,
  input  logic signed [SAMPLE_WIDTH-1:0] i_zero,
  input  logic [mpcsce_pkg::LIM_W-1:0]   lim,
  output logic                           over_r
);
  import mpcsce_pkg::*;

  localparam int PW = SAMPLE_WIDTH + 16;
  localparam int AW = PW + 2;
  localparam int LW = LIM_W + 15;
  localparam int CW = (AW > LW) ? AW : LW;

  logic signed [PW-1:0] pa_nxt, pb_nxt, pz_nxt;
  logic signed [PW-1:0] pa_r, pb_r, pz_r;
  logic signed [AW-1:0] acc;
  logic [AW-1:0]        mag;
  logic                 over_nxt;

  // Products of the three current components with this row's entries.
  always_comb begin
    pa_nxt = i_alpha * C_ALPHA;
    pb_nxt = i_beta * C_BETA;
    pz_nxt = i_zero * C_ZERO;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      pz_r <= pz_nxt;
    end
  end

  // Full-precision phase current magnitude against the limit scaled to match.
  always_comb begin
    acc      = AW'(pa_r) + AW'(pb_r) + AW'(pz_r);
    mag      = acc[AW-1] ? AW'(-acc) : AW'(acc);
    over_nxt = CW'(mag) > (CW'(lim) << 15);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      over_r <= over_nxt;
    end
  end

endmodule

>>> design/mpcsce_merge.sv
// Merge stages: switch costs, penalties, weighting and final saturation.
module mpcsce_merge #(
  parameter int NUM_SWITCHES = 6
) (
  input  logic                               clk,
  input  mpcsce_pkg::stg_en_t                en,
  input  logic [mpcsce_pkg::MASK_W-1:0]      prev_switches,
  input  logic [mpcsce_pkg::MASK_W-1:0]      cand_switches,
  input  logic [mpcsce_pkg::QW_W-1:0]        quad_weight,
  input  logic [mpcsce_pkg::SWC_W-1:0]       switch_costs,
  input  logic signed [mpcsce_pkg::PEN_W-1:0] overcurrent_penalty,
  input  logic [mpcsce_pkg::SQ_W-1:0]        sq_0,
  input  logic [mpcsce_pkg::SQ_W-1:0]        sq_1,
  input  logic [mpcsce_pkg::SQ_W-1:0]        sq_2,
  input  logic [mpcsce_pkg::SQ_W-1:0]        sq_3,
  input  logic [mpcsce_pkg::SQ_W-1:0]        sq_4,
  input  logic [2:0]                         phase_over,
  output logic signed [mpcsce_pkg::COST_W-1:0] cost_r
);
  import mpcsce_pkg::*;

  localparam int RW   = SQ_W + 2;
  localparam int LO_W = 24;
  localparam int HI_W = SQ_W - LO_W;
  localparam int WW   = HI_W + QW_W + 16;
  localparam int TW   = SQ_W + 2;
  localparam logic signed [TW-1:0] OUT_MAX_X =
    {{(TW-COST_W+1){1'b0}}, {(COST_W-1){1'b1}}};
  localparam logic signed [TW-1:0] OUT_MIN_X = ~OUT_MAX_X;

  logic [MASK_W-1:0]          changed;
  logic signed [SMALL_W-1:0]  sw_sum_nxt, sw_sum_r, sw_sum2_r;
  logic signed [SMALL_W-1:0]  small_nxt, small3_r, small4_r, small5_r, small6_r;
  logic [SQ_W:0]              s02_sum;
  logic [SQ_W-1:0]            s02_nxt, s02_r;
  logic [RW-1:0]              rest_nxt, rest3_r, rest4_r, rest5_r;
  logic [HI_W+QW_W-1:0]       hi_p_r;
  logic [LO_W+QW_W-1:0]       lo_p_r;
  logic [WW-1:0]              w8;
  logic [SQ_W-1:0]            wcap_nxt, wcap_r;
  logic [RW-1:0]              posu;
  logic [SQ_W-1:0]            pos_nxt, pos_r;
  logic signed [TW-1:0]       total;
  logic signed [COST_W-1:0]   cost_nxt;

  // Stage 1: signed cost of every switch that changes.
  always_comb begin
    changed    = prev_switches ^ cand_switches;
    sw_sum_nxt = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < NUM_SWITCHES && changed[i]) begin
        sw_sum_nxt = sw_sum_nxt + SMALL_W'($signed(switch_costs[4*i +: 4]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sw_sum_r <= sw_sum_nxt;
    end
    if (en[1]) begin
      sw_sum2_r <= sw_sum_r;
    end
  end

  // Stage 3: weighted pair sum, plain sum and the integer cost terms.
  always_comb begin
    s02_sum  = (SQ_W+1)'(sq_0) + (SQ_W+1)'(sq_2);
    s02_nxt  = (s02_sum > (SQ_W+1)'(SQ_CAP)) ? SQ_CAP : s02_sum[SQ_W-1:0];
    rest_nxt = RW'(sq_1) + RW'(sq_3) + RW'(sq_4);
    small_nxt = sw_sum2_r;
    for (int j = 0; j < 3; j++) begin
      if (phase_over[j]) begin
        small_nxt = small_nxt + SMALL_W'(overcurrent_penalty);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s02_r    <= s02_nxt;
      rest3_r  <= rest_nxt;
      small3_r <= small_nxt;
    end
  end

  // Stage 4: the weight product split into two partial products.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      hi_p_r   <= s02_r[SQ_W-1:LO_W] * quad_weight;
      lo_p_r   <= s02_r[LO_W-1:0] * quad_weight;
      rest4_r  <= rest3_r;
      small4_r <= small3_r;
    end
  end

  // Stage 5: recombine, drop the eight weight fraction bits, saturate.
  always_comb begin
    w8       = {hi_p_r, 16'b0} + WW'(lo_p_r[LO_W+QW_W-1:8]);
    wcap_nxt = (w8 > WW'(SQ_CAP)) ? SQ_CAP : w8[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      wcap_r   <= wcap_nxt;
      rest5_r  <= rest4_r;
      small5_r <= small4_r;
    end
  end

  // Stage 6: all non-negative terms, saturated at the cap.
  always_comb begin
    posu    = RW'(wcap_r) + rest5_r;
    pos_nxt = (posu > RW'(SQ_CAP)) ? SQ_CAP : posu[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pos_r    <= pos_nxt;
      small6_r <= small5_r;
    end
  end

  // Stage 7: add the integer terms at 2^16 and clip to the output range.
  always_comb begin
    total = $signed(TW'(pos_r)) + (TW'(small6_r) <<< 16);
    if (total > OUT_MAX_X) begin
      cost_nxt = OUT_MAX_X[COST_W-1:0];
    end else if (total < OUT_MIN_X) begin
      cost_nxt = OUT_MIN_X[COST_W-1:0];
    end else begin
      cost_nxt = total[COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      cost_r <= cost_nxt;
    end
  end

endmodule

>>> design/mpc_switching_cost_evaluator.sv
// Top level of the predictive control switching cost evaluator.
// An accepted request runs through the lane and merge stages to its cost on the output register.
// Throughput: one candidate per cycle while the output is taken; five squared-error lanes and three phase
// lanes run side by side into a five-stage merge, all under one valid chain.
// Any stage with a bubble loads even while the output holds a waiting cost.
// Reset (synchronous, rst_n low) empties the pipeline and restores the registers.
module mpc_switching_cost_evaluator #(
  parameter int NUM_SWITCHES = 6,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mpcsce_in_if.sink                        in_ch,
  mpcsce_out_if.source                     out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mpcsce_pkg::ADDR_W-1:0]    paddr,
  input  logic [mpcsce_pkg::DATA_W-1:0]    pwdata,
  output logic [mpcsce_pkg::DATA_W-1:0]    prdata,
  output logic                             pready
);
  import mpcsce_pkg::*;

  logic [QW_W-1:0]          qw_r;
  logic [SWC_W-1:0]         swc_r;
  logic signed [PEN_W-1:0]  pen_r;
  logic [LIM_W-1:0]         lim_r;
  reg_idx_t                 reg_idx;
  logic                     cfg_wr;

  logic [NSTG-1:0]          stg_vld_r;
  logic [NSTG-1:0]          stg_vld_nxt;
  stg_en_t                  stg_en;

  logic [SQ_W-1:0]          sq [5];
  logic [2:0]               phase_over;
  logic signed [COST_W-1:0] cost_r;

  // Register port: writes complete in the access phase, reads are immediate.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r  <= QW_W'(256);
      swc_r <= '0;
      pen_r <= '0;
      lim_r <= '1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_QUAD_WEIGHT:   qw_r  <= pwdata[QW_W-1:0];
        REG_SWITCH_COSTS:  swc_r <= pwdata[SWC_W-1:0];
        REG_OC_PENALTY:    pen_r <= pwdata[PEN_W-1:0];
        REG_CURRENT_LIMIT: lim_r <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUAD_WEIGHT:   prdata = DATA_W'(qw_r);
      REG_SWITCH_COSTS:  prdata = DATA_W'(swc_r);
      REG_OC_PENALTY:    prdata = DATA_W'($unsigned(pen_r));
      REG_CURRENT_LIMIT: prdata = DATA_W'(lim_r);
      default:           prdata = '0;
    endcase
  end

  // Valid chain: a stage loads when it is empty or the next one loads.
  always_comb begin
    stg_en[NSTG-1] = !stg_vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_en[k] = !stg_vld_r[k] || stg_en[k+1];
    end
    stg_vld_nxt = stg_vld_r;
    if (stg_en[0]) begin
      stg_vld_nxt[0] = in_ch.valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (stg_en[k]) begin
        stg_vld_nxt[k] = stg_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  assign in_ch.ready  = stg_en[0];
  assign out_ch.valid = stg_vld_r[NSTG-1];
  assign out_ch.cost  = cost_r;

  // Squared-error lanes, one per state element.
  mpcsce_sq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sq_0 (
    .clk(clk), .en(stg_en[1:0]), .ref_i(in_ch.ref_0), .meas_i(in_ch.meas_0), .sq_r(sq[0])
  );
  mpcsce_sq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sq_1 (
    .clk(clk), .en(stg_en[1:0]), .ref_i(in_ch.ref_1), .meas_i(in_ch.meas_1), .sq_r(sq[1])
  );
  mpcsce_sq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sq_2 (
    .clk(clk), .en(stg_en[1:0]), .ref_i(in_ch.ref_2), .meas_i(in_ch.meas_2), .sq_r(sq[2])
  );
  mpcsce_sq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sq_3 (
    .clk(clk), .en(stg_en[1:0]), .ref_i(in_ch.ref_3), .meas_i(in_ch.meas_3), .sq_r(sq[3])
  );
  mpcsce_sq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sq_4 (
    .clk(clk), .en(stg_en[1:0]), .ref_i(in_ch.ref_4), .meas_i(in_ch.meas_4), .sq_r(sq[4])
  );

  // Phase current lanes, one per matrix row.
  mpcsce_phase_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH), .C_ALPHA(M_AA), .C_BETA(16'sd0), .C_ZERO(M_ZZ)
  ) u_phase_a (
    .clk(clk), .en(stg_en[1:0]), .i_alpha(in_ch.meas_1), .i_beta(in_ch.meas_3),
    .i_zero(in_ch.meas_4), .lim(lim_r), .over_r(phase_over[0])
  );
  mpcsce_phase_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH), .C_ALPHA(M_BA), .C_BETA(M_BB), .C_ZERO(M_ZZ)
  ) u_phase_b (
    .clk(clk), .en(stg_en[1:0]), .i_alpha(in_ch.meas_1), .i_beta(in_ch.meas_3),
    .i_zero(in_ch.meas_4), .lim(lim_r), .over_r(phase_over[1])
  );
  mpcsce_phase_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH), .C_ALPHA(M_BA), .C_BETA(-M_BB), .C_ZERO(M_ZZ)
  ) u_phase_c (
    .clk(clk), .en(stg_en[1:0]), .i_alpha(in_ch.meas_1), .i_beta(in_ch.meas_3),
    .i_zero(in_ch.meas_4), .lim(lim_r), .over_r(phase_over[2])
  );

  // Merge of all lane results into the final cost.
  mpcsce_merge #(.NUM_SWITCHES(NUM_SWITCHES)) u_merge (
    .clk                 (clk),
    .en                  (stg_en),
    .prev_switches       (in_ch.prev_switches),
    .cand_switches       (in_ch.cand_switches),
    .quad_weight         (qw_r),
    .switch_costs        (swc_r),
    .overcurrent_penalty (pen_r),
    .sq_0                (sq[0]),
    .sq_1                (sq[1]),
    .sq_2                (sq[2]),
    .sq_3                (sq[3]),
    .sq_4                (sq[4]),
    .phase_over          (phase_over),
    .cost_r              (cost_r)
  );

`ifndef SYNTH
  // A full pipeline with a stalled output must refuse new requests.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&stg_vld_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request accepted while the pipeline is full and stalled");

  // A valid first stage that cannot move on keeps its request.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r[0] && !stg_en[1]) |=> stg_vld_r[0])
    else $error("first stage request lost during a stall");

  // A result only appears after the stage before the output held one.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(stg_vld_r[NSTG-2]))
    else $error("output became valid without a request behind it");

  // An accepted request always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> stg_vld_r[0])
    else $error("accepted request missing from the first stage");
`endif

endmodule

>>> test/mpc_switching_cost_evaluator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the switching cost evaluator with its own cost predictor.
module mpc_switching_cost_evaluator_test;
  import mpcsce_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int NUM_SW = 6;
  localparam int RAND_PER_SETTING = 190;

  // Alpha-beta-zero to abc matrix, Q1.15.
  localparam longint ABC_AA = 26755;
  localparam longint ABC_BA = -13376;
  localparam longint ABC_BB = 23170;
  localparam longint ABC_ZZ = 18920;

  localparam longint SQ_SAT = longint'(1) << 48;
  localparam longint COST_MAX = (longint'(1) << 47) - 1;
  localparam longint COST_MIN = -(longint'(1) << 47);

  // One candidate: reference and predicted state plus both switch masks.
  typedef struct packed {
    logic [4:0][SAMPLE_W-1:0] rv;
    logic [4:0][SAMPLE_W-1:0] mv;
    logic [MASK_W-1:0]        prev;
    logic [MASK_W-1:0]        cand;
  } cand_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mpcsce_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  mpcsce_out_if out_ch ();

  mpc_switching_cost_evaluator #(
    .NUM_SWITCHES(NUM_SW),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Register shadow used by the predictor.
  logic [QW_W-1:0]         quad_weight_r;
  logic [SWC_W-1:0]        switch_costs_r;
  logic signed [PEN_W-1:0] oc_penalty_r;
  logic [LIM_W-1:0]        current_limit_r;

  cand_t queued_candidates[$];
  logic signed [COST_W-1:0] pending_costs[$];
  cand_t next_cand;
  cand_t seen_cand;
  logic signed [COST_W-1:0] want_cost;
  logic in_taken;
  int send_idle_pct;
  int recv_idle_pct;
  int n_accepted;
  int n_checked;
  int n_errors;
  int n_settings;

  // Expected cost of one candidate under the current register settings.
  function automatic logic signed [COST_W-1:0] candidate_cost(cand_t c);
    longint err;
    longint sq[5];
    longint pos_sum;
    longint units;
    longint ia;
    longint ib;
    longint iz;
    longint phase[3];
    longint thresh;
    longint total;
    for (int i = 0; i < 5; i++) begin
      err = longint'($signed(c.rv[i])) - longint'($signed(c.mv[i]));
      sq[i] = err * err;
    end
    // Weighted terms keep floor of the Q8.8 product; all positive terms saturate.
    pos_sum = ((sq[0] + sq[2]) * longint'(quad_weight_r)) >>> 8;
    if (pos_sum > SQ_SAT) pos_sum = SQ_SAT;
    pos_sum = pos_sum + sq[1];
    if (pos_sum > SQ_SAT) pos_sum = SQ_SAT;
    pos_sum = pos_sum + sq[3];
    if (pos_sum > SQ_SAT) pos_sum = SQ_SAT;
    pos_sum = pos_sum + sq[4];
    if (pos_sum > SQ_SAT) pos_sum = SQ_SAT;

    // Cost of each switch that changes, signed nibble per switch.
    units = 0;
    for (int s = 0; s < NUM_SW; s++) begin
      if (c.prev[s] ^ c.cand[s]) units += longint'($signed(switch_costs_r[4*s +: 4]));
    end

    // Phase currents at full precision against the limit, strictly above.
    ia = longint'($signed(c.mv[1]));
    ib = longint'($signed(c.mv[3]));
    iz = longint'($signed(c.mv[4]));
    phase[0] = ABC_AA * ia + ABC_ZZ * iz;
    phase[1] = ABC_BA * ia + ABC_BB * ib + ABC_ZZ * iz;
    phase[2] = ABC_BA * ia - ABC_BB * ib + ABC_ZZ * iz;
    thresh = longint'(current_limit_r) << 15;
    for (int k = 0; k < 3; k++) begin
      if (phase[k] < 0) phase[k] = -phase[k];
      if (phase[k] > thresh) units += longint'(oc_penalty_r);
    end

    total = pos_sum + units * 65536;
    if (total > COST_MAX) total = COST_MAX;
    if (total < COST_MIN) total = COST_MIN;
    return total[COST_W-1:0];
  endfunction

  // Sample value: mostly full range, some small magnitudes, some extremes.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int k;
    k = $urandom_range(1, 14);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return SAMPLE_W'($urandom);
      5, 6, 7: return SAMPLE_W'(int'($urandom_range(0, 2 << k)) - (1 << k));
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic cand_t random_candidate();
    cand_t c;
    for (int i = 0; i < 5; i++) begin
      c.mv[i] = pick_sample();
      // A quarter of the references track the prediction closely.
      if ($urandom_range(0, 3) == 0) c.rv[i] = c.mv[i] + SAMPLE_W'($urandom_range(0, 31)) - 16'd16;
      else c.rv[i] = pick_sample();
    end
    c.prev = MASK_W'($urandom);
    case ($urandom_range(0, 3))
      0: c.cand = c.prev;
      1: c.cand = c.prev ^ (MASK_W'(1) << $urandom_range(0, MASK_W - 1));
      default: c.cand = MASK_W'($urandom);
    endcase
    return c;
  endfunction

  // Register write over the configuration port; shadow updates at the access edge.
  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_QUAD_WEIGHT: quad_weight_r = value[QW_W-1:0];
      REG_SWITCH_COSTS: switch_costs_r = value[SWC_W-1:0];
      REG_OC_PENALTY: oc_penalty_r = value[PEN_W-1:0];
      REG_CURRENT_LIMIT: current_limit_r = value[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_all_regs(logic [DATA_W-1:0] qw, logic [DATA_W-1:0] swc,
                                logic [DATA_W-1:0] pen, logic [DATA_W-1:0] lim);
    cfg_write(REG_QUAD_WEIGHT, qw);
    cfg_write(REG_SWITCH_COSTS, swc);
    cfg_write(REG_OC_PENALTY, pen);
    cfg_write(REG_CURRENT_LIMIT, lim);
    n_settings++;
  endtask

  // Random settings, upper bus bits left random; limits often kept low.
  task automatic write_random_regs();
    logic [DATA_W-1:0] lim;
    lim = $urandom;
    if ($urandom_range(0, 1) == 0) lim = (lim & 32'hFFFF_8000) | $urandom_range(0, 4000);
    write_all_regs($urandom, $urandom, $urandom, lim);
  endtask

  // Extremes of the fields, zero error, limit boundary and switch edge cases.
  task automatic push_directed();
    cand_t d;
    d = '0;
    queued_candidates.push_back(d);
    d.rv = {5{16'h7FFF}};
    d.mv = {5{16'h8000}};
    d.cand = 6'h3F;
    queued_candidates.push_back(d);
    d.rv = {5{16'h8000}};
    d.mv = {5{16'h7FFF}};
    d.prev = 6'h3F;
    d.cand = 6'h00;
    queued_candidates.push_back(d);
    d.rv = {16'h1234, 16'hEDCB, 16'h0101, 16'hFF00, 16'h5A5A};
    d.mv = d.rv;
    d.prev = 6'h2A;
    d.cand = 6'h2A;
    queued_candidates.push_back(d);
    // All three phases sit exactly on a limit of 2365, then just above it.
    d = '0;
    d.mv[4] = 16'd4096;
    d.prev = 6'h01;
    queued_candidates.push_back(d);
    d.mv[4] = 16'd4097;
    queued_candidates.push_back(d);
    d.mv[4] = -16'sd4097;
    queued_candidates.push_back(d);
    d = '0;
    d.mv[1] = 16'h7FFF;
    d.mv[3] = 16'h7FFF;
    d.mv[4] = 16'h7FFF;
    d.prev = 6'h15;
    d.cand = 6'h2A;
    queued_candidates.push_back(d);
    d.mv[1] = 16'h8000;
    d.mv[3] = 16'h8000;
    d.mv[4] = 16'h8000;
    queued_candidates.push_back(d);
    d.mv[1] = 16'h7FFF;
    d.mv[4] = 16'h0000;
    d.prev = 6'h20;
    d.cand = 6'h00;
    queued_candidates.push_back(d);
    // Weighted elements only.
    d = '0;
    d.rv[0] = 16'h7FFF;
    d.mv[0] = 16'h8000;
    d.rv[2] = 16'h8000;
    d.mv[2] = 16'h7FFF;
    queued_candidates.push_back(d);
    d.rv[0] = 16'h0001;
    d.mv[0] = 16'h0000;
    d.rv[2] = 16'h0000;
    d.mv[2] = 16'h0000;
    queued_candidates.push_back(d);
  endtask

  task automatic push_random(int count);
    for (int n = 0; n < count; n++) queued_candidates.push_back(random_candidate());
  endtask

  // Block until every queued request has been sent and every cost has returned.
  task automatic wait_drained();
    while (queued_candidates.size() != 0 || in_ch.valid || pending_costs.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Candidate driver: a new request goes out once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (queued_candidates.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_cand = queued_candidates.pop_front();
        in_ch.ref_0 <= next_cand.rv[0];
        in_ch.ref_1 <= next_cand.rv[1];
        in_ch.ref_2 <= next_cand.rv[2];
        in_ch.ref_3 <= next_cand.rv[3];
        in_ch.ref_4 <= next_cand.rv[4];
        in_ch.meas_0 <= next_cand.mv[0];
        in_ch.meas_1 <= next_cand.mv[1];
        in_ch.meas_2 <= next_cand.mv[2];
        in_ch.meas_3 <= next_cand.mv[3];
        in_ch.meas_4 <= next_cand.mv[4];
        in_ch.prev_switches <= next_cand.prev;
        in_ch.cand_switches <= next_cand.cand;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side backpressure.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Predict on every accepted candidate and check every delivered cost in order.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_cand.rv = {in_ch.ref_4, in_ch.ref_3, in_ch.ref_2, in_ch.ref_1, in_ch.ref_0};
      seen_cand.mv = {in_ch.meas_4, in_ch.meas_3, in_ch.meas_2, in_ch.meas_1, in_ch.meas_0};
      seen_cand.prev = in_ch.prev_switches;
      seen_cand.cand = in_ch.cand_switches;
      pending_costs.push_back(candidate_cost(seen_cand));
      n_accepted++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_costs.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("Unexpected cost %0d with no request outstanding", out_ch.cost);
      end else begin
        want_cost = pending_costs.pop_front();
        n_checked++;
        if (out_ch.cost !== want_cost) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Cost mismatch on result %0d: expected %0d (0x%h), got %0d (0x%h)",
                     n_checked, want_cost, want_cost, out_ch.cost, out_ch.cost);
        end
      end
    end
  end

  // Stimulus sequence: directed candidates, then random ones under varied settings.
  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.ref_0 = '0;
    in_ch.ref_1 = '0;
    in_ch.ref_2 = '0;
    in_ch.ref_3 = '0;
    in_ch.ref_4 = '0;
    in_ch.meas_0 = '0;
    in_ch.meas_1 = '0;
    in_ch.meas_2 = '0;
    in_ch.meas_3 = '0;
    in_ch.meas_4 = '0;
    in_ch.prev_switches = '0;
    in_ch.cand_switches = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    quad_weight_r = 16'd256;
    switch_costs_r = '0;
    oc_penalty_r = '0;
    current_limit_r = 15'd32767;
    send_idle_pct = 32;
    recv_idle_pct = 51;
    n_accepted = 0;
    n_checked = 0;
    n_errors = 0;
    n_settings = 1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings.
    push_directed();
    wait_drained();

    // Mixed switch costs, top penalty and a limit right at a reachable phase current.
    write_all_regs(32'h0000_FFFF, 32'h0087_F109, 32'h0000_0007, 32'd2365);
    push_directed();
    wait_drained();

    // Lowest settings, then highest.
    write_all_regs(32'h0, 32'h0088_8888, 32'h0000_0008, 32'h0);
    push_random(RAND_PER_SETTING);
    wait_drained();
    write_all_regs(32'h0000_FFFF, 32'h0077_7777, 32'h0000_0007, 32'h0000_7FFF);
    push_random(RAND_PER_SETTING);
    wait_drained();

    // Receiver mostly ready, sender sparse.
    send_idle_pct = 51;
    recv_idle_pct = 32;
    for (int p = 0; p < 2; p++) begin
      write_random_regs();
      push_random(RAND_PER_SETTING);
      wait_drained();
    end

    // Full rate in both directions.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int p = 0; p < 2; p++) begin
      write_random_regs();
      push_random(RAND_PER_SETTING);
      wait_drained();
    end

    repeat (2 * NSTG) @(posedge clk);
    $display("Scored %0d candidates under %0d register settings; %0d costs checked.",
             n_accepted, n_settings, n_checked);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
